@@ hdl/swlc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swlc_pkg
// Shared types and constants of the square window line clipper.
// ----------------------------------------------------------------------------
package swlc_pkg;

    localparam int COORD_BITS = 16;
    localparam int HALF_BITS  = 15;
    localparam logic [HALF_BITS-1:0] HALF_RESET = 15'd4915;

    // Width of the edge terms p and q, wide enough for a coordinate plus the half size.
    localparam int P_BITS = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 2;

    // Divisor and dividend magnitudes never exceed the largest coordinate difference.
    localparam int DEN_BITS  = COORD_BITS;
    localparam int REM_BITS  = DEN_BITS + 1;
    localparam int T_FRAC    = 28;
    localparam int T_BITS    = T_FRAC + 1;
    localparam int PROD_BITS = DEN_BITS + T_BITS;
    localparam logic [T_BITS-1:0] T_ONE = {1'b1, {T_FRAC{1'b0}}};

    localparam int NUM_EDGES  = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [1:0] {
        EDGE_NONE,
        EDGE_ENTRY,
        EDGE_EXIT,
        EDGE_REJECT
    } t_edge_kind;

    typedef struct packed {
        t_edge_kind            kind;
        logic [DEN_BITS-1:0]   num;
        logic [DEN_BITS-1:0]   den;
    } t_edge;

    typedef struct packed {
        t_edge [NUM_EDGES-1:0]          edges;
        logic signed [COORD_BITS-1:0]   x0;
        logic signed [COORD_BITS-1:0]   y0;
        logic signed [P_BITS-1:0]       dx;
        logic signed [P_BITS-1:0]       dy;
    } t_seg;

endpackage
`default_nettype wire

@@ hdl/square_window_line_clipper_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// square_window_line_clipper_top
// Cyrus-Beck clipping of segments against an origin-centered square window.
// ----------------------------------------------------------------------------
// The block accepts one segment per clock cycle while its queue is not full and
// returns one result per segment in order. The result passes through the queue,
// the 29 register stages of the divider pipeline that forms the edge parameters,
// then the merge, multiply and output registers. A stall on the master side holds
// the whole back part, and the input keeps accepting until the four-entry
// queue is full. The window half size is written through i_cfg_wr_en and
// i_cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module square_window_line_clipper_top
    import swlc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [HALF_BITS-1:0]    i_cfg_wr_data,
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  wire logic [4*COORD_BITS-1:0] i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y
    output logic [4*COORD_BITS-1:0]      o_m_axis_tdata,
    // visible
    output logic                         o_m_axis_tuser
);

    logic [HALF_BITS-1:0] r_half_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_size <= HALF_RESET;
        end else if (i_cfg_wr_en) begin
            r_half_size <= i_cfg_wr_data;
        end
    end

    t_seg w_front_seg, w_head_seg;
    logic w_full, w_empty, w_pop, w_push;

    swlc_front u_front (
        .i_start_x  (i_s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
        .i_start_y  (i_s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
        .i_end_x    (i_s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
        .i_end_y    (i_s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
        .i_half_size(r_half_size),
        .o_seg      (w_front_seg)
    );

    assign o_s_axis_tready = !w_full;
    assign w_push          = i_s_axis_tvalid && !w_full;

    swlc_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_front_seg),
        .i_pop  (w_pop),
        .o_data (w_head_seg),
        .o_full (w_full),
        .o_empty(w_empty)
    );

    swlc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg_avail   (!w_empty),
        .i_seg         (w_head_seg),
        .o_pop         (w_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_visible     (o_m_axis_tuser),
        .o_clip_start_x(o_m_axis_tdata[0*COORD_BITS +: COORD_BITS]),
        .o_clip_start_y(o_m_axis_tdata[1*COORD_BITS +: COORD_BITS]),
        .o_clip_end_x  (o_m_axis_tdata[2*COORD_BITS +: COORD_BITS]),
        .o_clip_end_y  (o_m_axis_tdata[3*COORD_BITS +: COORD_BITS])
    );

endmodule
`default_nettype wire

@@ hdl/swlc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swlc_front
// Classifies each window edge of an incoming segment: ignored, rejecting,
// entering or leaving, with the dividend and divisor of its parameter.
// ----------------------------------------------------------------------------
module swlc_front
    import swlc_pkg::*;
(
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic [HALF_BITS-1:0]         i_half_size,
    output t_seg                              o_seg
);

    function automatic t_edge classify(input logic signed [P_BITS-1:0] p,
                                       input logic signed [P_BITS-1:0] q);
        t_edge                     e;
        logic signed [P_BITS-1:0]  ap;
        logic signed [P_BITS-1:0]  nq;
        e.kind = EDGE_NONE;
        e.num  = '0;
        e.den  = '0;
        ap = -p;
        nq = -q;
        if (p == '0) begin
            if (q < 0) e.kind = EDGE_REJECT;
        end else if (p < 0) begin
            if (nq <= 0) begin
                e.kind = EDGE_NONE;
            end else if (nq > ap) begin
                e.kind = EDGE_REJECT;
            end else begin
                e.kind = EDGE_ENTRY;
                e.num  = nq[DEN_BITS-1:0];
                e.den  = ap[DEN_BITS-1:0];
            end
        end else begin
            if (q < 0) begin
                e.kind = EDGE_REJECT;
            end else if (q >= p) begin
                e.kind = EDGE_NONE;
            end else begin
                e.kind = EDGE_EXIT;
                e.num  = q[DEN_BITS-1:0];
                e.den  = p[DEN_BITS-1:0];
            end
        end
        return e;
    endfunction

    logic signed [P_BITS-1:0] w_x0, w_y0, w_x1, w_y1, w_lim, w_dx, w_dy;

    always_comb begin
        w_x0  = P_BITS'(i_start_x);
        w_y0  = P_BITS'(i_start_y);
        w_x1  = P_BITS'(i_end_x);
        w_y1  = P_BITS'(i_end_y);
        w_lim = $signed({{(P_BITS-HALF_BITS){1'b0}}, i_half_size});
        w_dx  = w_x1 - w_x0;
        w_dy  = w_y1 - w_y0;

        o_seg.edges[0] = classify(-w_dx, w_x0 + w_lim);
        o_seg.edges[1] = classify(w_dx, w_lim - w_x0);
        o_seg.edges[2] = classify(-w_dy, w_y0 + w_lim);
        o_seg.edges[3] = classify(w_dy, w_lim - w_y0);
        o_seg.x0 = i_start_x;
        o_seg.y0 = i_start_y;
        o_seg.dx = w_dx;
        o_seg.dy = w_dy;
    end

endmodule
`default_nettype wire

@@ hdl/swlc_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swlc_fifo
// Short queue of classified segments between the front and the back part.
// ----------------------------------------------------------------------------
module swlc_fifo
    import swlc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_seg i_data,
    input  wire logic i_pop,
    output t_seg      o_data,
    output logic      o_full,
    output logic      o_empty
);

    t_seg               r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);

endmodule
`default_nettype wire

@@ hdl/swlc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swlc_div
// Pipelined restoring divider for num * 2^T_FRAC / den with num <= den.
// One quotient bit per stage; also reports a nonzero remainder.
// ----------------------------------------------------------------------------
module swlc_div
    import swlc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [DEN_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic [T_BITS-1:0]        o_quot,
    output logic                     o_rem_nz
);

    logic [REM_BITS-1:0] r_rem [0:T_FRAC];
    logic [DEN_BITS-1:0] r_den [0:T_FRAC];
    logic [T_FRAC-1:0]   r_quo [0:T_FRAC];
    logic                r_one [0:T_FRAC];

    // The integer bit is set only when num equals den; the fraction is then zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_one[0] <= (i_num == i_den);
            r_rem[0] <= (i_num == i_den) ? '0 : {1'b0, i_num};
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 1; k <= T_FRAC; k++) begin : g_stage
        logic [REM_BITS-1:0] w_shift;
        logic                w_ge;
        assign w_shift = {r_rem[k-1][REM_BITS-2:0], 1'b0};
        assign w_ge    = (w_shift >= {1'b0, r_den[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? (w_shift - {1'b0, r_den[k-1]}) : w_shift;
                r_quo[k] <= {r_quo[k-1][T_FRAC-2:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_one[k] <= r_one[k-1];
            end
        end
    end

    assign o_quot   = {r_one[T_FRAC], r_quo[T_FRAC]};
    assign o_rem_nz = (r_rem[T_FRAC] != '0);

endmodule
`default_nettype wire

@@ hdl/swlc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swlc_back
// Divides the parameter of every window edge, merges them into entry and exit,
// interpolates the clipped endpoints and holds the result for the master side.
// ----------------------------------------------------------------------------
module swlc_back
    import swlc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_seg_avail,
    input  wire t_seg                  i_seg,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_visible,
    output logic [COORD_BITS-1:0]      o_clip_start_x,
    output logic [COORD_BITS-1:0]      o_clip_start_y,
    output logic [COORD_BITS-1:0]      o_clip_end_x,
    output logic [COORD_BITS-1:0]      o_clip_end_y
);

    function automatic logic [COORD_BITS-1:0] place(
        input logic signed [COORD_BITS-1:0] base,
        input logic                         neg,
        input logic [PROD_BITS-1:0]         prod);
        logic [PROD_BITS-1:0]       sum;
        logic signed [COORD_BITS:0] ext;
        logic signed [COORD_BITS:0] rr;
        logic signed [COORD_BITS:0] res;
        sum = prod + (PROD_BITS'(1) << (T_FRAC - 1));
        ext = {base[COORD_BITS-1], base};
        rr  = $signed({1'b0, sum[T_FRAC +: DEN_BITS]});
        res = neg ? (ext - rr) : (ext + rr);
        return res[COORD_BITS-1:0];
    endfunction

    logic w_en;
    assign w_en  = !o_valid || i_ready;
    assign o_pop = w_en && i_seg_avail;

    // Segment shift line alongside the dividers.
    t_seg r_seg [0:T_FRAC];
    logic r_vld [0:T_FRAC];

    always_ff @(posedge i_clk) begin
        if (w_en) r_seg[0] <= i_seg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_seg_avail;
        end
    end

    for (genvar k = 1; k <= T_FRAC; k++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (w_en) r_seg[k] <= r_seg[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    logic [T_BITS-1:0] w_quot [0:NUM_EDGES-1];
    logic              w_rem_nz [0:NUM_EDGES-1];

    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_div
        swlc_div u_div (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_num   (i_seg.edges[e].num),
            .i_den   (i_seg.edges[e].den),
            .o_quot  (w_quot[e]),
            .o_rem_nz(w_rem_nz[e])
        );
    end

    // Entry parameters round up, exit parameters round down.
    logic [T_BITS-1:0] w_t_in, w_t_out, w_ceil;
    logic              w_reject;

    always_comb begin
        t_seg s;
        s        = r_seg[T_FRAC];
        w_t_in   = '0;
        w_t_out  = T_ONE;
        w_reject = 1'b0;
        w_ceil   = '0;
        for (int e = 0; e < NUM_EDGES; e++) begin
            w_ceil = w_quot[e] + T_BITS'(w_rem_nz[e]);
            case (s.edges[e].kind)
                EDGE_ENTRY:  if (w_ceil > w_t_in) w_t_in = w_ceil;
                EDGE_EXIT:   if (w_quot[e] < w_t_out) w_t_out = w_quot[e];
                EDGE_REJECT: w_reject = 1'b1;
                default:     ;
            endcase
        end
    end

    // Merge stage.
    logic                         r_c_vld, r_c_vis;
    logic [T_BITS-1:0]            r_c_t_in, r_c_t_out;
    t_seg                         r_c_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_vld[T_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_vis   <= !w_reject && (w_t_in <= w_t_out);
            r_c_t_in  <= w_t_in;
            r_c_t_out <= w_t_out;
            r_c_seg   <= r_seg[T_FRAC];
        end
    end

    // Multiply stage.
    logic [DEN_BITS-1:0]  w_mag_x, w_mag_y;
    logic signed [P_BITS-1:0] w_neg_dx, w_neg_dy;

    always_comb begin
        w_neg_dx = -r_c_seg.dx;
        w_neg_dy = -r_c_seg.dy;
        w_mag_x  = r_c_seg.dx[P_BITS-1] ? w_neg_dx[DEN_BITS-1:0] : r_c_seg.dx[DEN_BITS-1:0];
        w_mag_y  = r_c_seg.dy[P_BITS-1] ? w_neg_dy[DEN_BITS-1:0] : r_c_seg.dy[DEN_BITS-1:0];
    end

    logic                         r_m_vld, r_m_vis, r_m_neg_x, r_m_neg_y;
    logic signed [COORD_BITS-1:0] r_m_x0, r_m_y0;
    logic [PROD_BITS-1:0]         r_m_sx, r_m_sy, r_m_ex, r_m_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_vis   <= r_c_vis;
            r_m_neg_x <= r_c_seg.dx[P_BITS-1];
            r_m_neg_y <= r_c_seg.dy[P_BITS-1];
            r_m_x0    <= r_c_seg.x0;
            r_m_y0    <= r_c_seg.y0;
            r_m_sx    <= PROD_BITS'(w_mag_x) * PROD_BITS'(r_c_t_in);
            r_m_sy    <= PROD_BITS'(w_mag_y) * PROD_BITS'(r_c_t_in);
            r_m_ex    <= PROD_BITS'(w_mag_x) * PROD_BITS'(r_c_t_out);
            r_m_ey    <= PROD_BITS'(w_mag_y) * PROD_BITS'(r_c_t_out);
        end
    end

    // Output register; a hidden segment reports all-zero coordinates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_visible      <= r_m_vis;
            o_clip_start_x <= r_m_vis ? place(r_m_x0, r_m_neg_x, r_m_sx) : '0;
            o_clip_start_y <= r_m_vis ? place(r_m_y0, r_m_neg_y, r_m_sy) : '0;
            o_clip_end_x   <= r_m_vis ? place(r_m_x0, r_m_neg_x, r_m_ex) : '0;
            o_clip_end_y   <= r_m_vis ? place(r_m_y0, r_m_neg_y, r_m_ey) : '0;
        end
    end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square window line clipper testbench
// Sends directed and random segments through the stream input, predicts each
// clipped segment with a local Cyrus-Beck model and compares every returned
// transaction in order, under random stalls on both sides and several window
// sizes.
// ----------------------------------------------------------------------------
module testbench
    import swlc_pkg::*;
();

    localparam int TF = 28;
    localparam longint ONE_T = longint'(1) << TF;
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic                           visible;
        logic signed [COORD_BITS-1:0]   sx;
        logic signed [COORD_BITS-1:0]   sy;
        logic signed [COORD_BITS-1:0]   ex;
        logic signed [COORD_BITS-1:0]   ey;
    } t_clip;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [HALF_BITS-1:0]    i_cfg_wr_data;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [4*COORD_BITS-1:0] i_s_axis_tdata;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [4*COORD_BITS-1:0] o_m_axis_tdata;
    logic                    o_m_axis_tuser;

    logic [HALF_BITS-1:0] window_half;
    t_clip                clip_queue[$];
    int                   error_count;
    int                   idle_cycles;
    int                   ready_hold;
    bit                   timed_out;

    square_window_line_clipper_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Updates the entry or exit parameter for one edge, or flags a rejection.
    function automatic void apply_edge(input longint p, input longint q,
                                       inout longint t_entry, inout longint t_exit,
                                       inout bit rejected);
        longint t;
        longint ap;
        begin
            if (p == 0) begin
                if (q < 0) rejected = 1'b1;
            end else if (p < 0) begin
                ap = -p;
                if (-q > 0) begin
                    if (-q > ap) t = ONE_T + 1;
                    else t = (((-q) <<< TF) + ap - 1) / ap;
                    if (t > t_entry) t_entry = t;
                end
            end else begin
                if (q < 0) t = -1;
                else if (q >= p) t = t_exit;
                else t = (q <<< TF) / p;
                if (t < t_exit) t_exit = t;
            end
        end
    endfunction

    function automatic logic [COORD_BITS-1:0] point_at(input longint base,
                                                        input longint delta,
                                                        input longint t);
        longint mag;
        longint r;
        begin
            mag = (delta < 0) ? -delta : delta;
            r = (mag * t + (longint'(1) << (TF - 1))) >>> TF;
            point_at = COORD_BITS'((delta < 0) ? base - r : base + r);
        end
    endfunction

    function automatic t_clip clip_segment(input logic [4*COORD_BITS-1:0] seg);
        longint x0, y0, x1, y1, lim, dx, dy, t_entry, t_exit;
        bit rejected;
        t_clip res;
        begin
            x0 = longint'($signed(seg[0*COORD_BITS +: COORD_BITS]));
            y0 = longint'($signed(seg[1*COORD_BITS +: COORD_BITS]));
            x1 = longint'($signed(seg[2*COORD_BITS +: COORD_BITS]));
            y1 = longint'($signed(seg[3*COORD_BITS +: COORD_BITS]));
            lim = longint'(window_half);
            dx = x1 - x0;
            dy = y1 - y0;
            t_entry = 0;
            t_exit = ONE_T;
            rejected = 1'b0;
            apply_edge(-dx, x0 + lim, t_entry, t_exit, rejected);
            apply_edge(dx, lim - x0, t_entry, t_exit, rejected);
            apply_edge(-dy, y0 + lim, t_entry, t_exit, rejected);
            apply_edge(dy, lim - y0, t_entry, t_exit, rejected);
            res = '0;
            if (!rejected && t_entry <= t_exit) begin
                res.visible = 1'b1;
                res.sx = point_at(x0, dx, t_entry);
                res.sy = point_at(y0, dy, t_entry);
                res.ex = point_at(x0, dx, t_exit);
                res.ey = point_at(y0, dy, t_exit);
            end
            clip_segment = res;
        end
    endfunction

    function automatic int gap_length();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55) gap_length = 0;
            else if (roll < 93) gap_length = $urandom_range(1, 3);
            else gap_length = $urandom_range(10, 40);
        end
    endfunction

    // Stretches without gaps alternate with stretches of random gaps.
    bit calm_mode;

    task automatic send_segment(input logic signed [COORD_BITS-1:0] sx,
                                input logic signed [COORD_BITS-1:0] sy,
                                input logic signed [COORD_BITS-1:0] ex,
                                input logic signed [COORD_BITS-1:0] ey);
        int gap;
        logic [4*COORD_BITS-1:0] seg;
        begin
            gap = calm_mode ? 0 : gap_length();
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            seg = {ey, ex, sy, sx};
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata <= seg;
            @(posedge i_clk);
            while (!o_s_axis_tready) @(posedge i_clk);
            clip_queue = {clip_queue, clip_segment(seg)};
        end
    endtask

    task automatic stop_sending();
        begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        begin
            stop_sending();
            while (clip_queue.size() != 0 && !timed_out) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic set_window(input logic [HALF_BITS-1:0] half);
        begin
            wait_drained();
            i_cfg_wr_en <= 1'b1;
            i_cfg_wr_data <= half;
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            window_half = half;
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        logic signed [COORD_BITS-1:0] h;
        begin
            h = COORD_BITS'(window_half);
            case ($urandom_range(0, 5))
                0: rand_coord = COORD_BITS'($urandom);
                1: rand_coord = $urandom_range(0, 1) ? h : -h;
                2: rand_coord = COORD_BITS'($signed(h) + $signed(COORD_BITS'($urandom_range(0, 4)) - 2));
                3: rand_coord = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                default: rand_coord = COORD_BITS'(int'($urandom_range(0, 2 * window_half))
                                                  - int'(window_half));
            endcase
        end
    endfunction

    task automatic test_directed();
        logic signed [COORD_BITS-1:0] h;
        begin
            h = COORD_BITS'(window_half);
            send_segment(-16'sd8000, 16'sd0, 16'sd8000, 16'sd0);      // crosses both sides of the reset-size window
            send_segment(16'sd100, 16'sd200, 16'sd300, -16'sd400);    // fully inside
            send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff); // extreme diagonal
            send_segment(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
            send_segment(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff); // point outside
            send_segment(16'sd10, -16'sd10, 16'sd10, -16'sd10);       // point inside
            send_segment(h, h, h, h);                                 // point on corner
            send_segment(h + 16'sd1, 16'sd0, h + 16'sd1, 16'sd0);
            send_segment(h + 16'sd1, -16'sd9000, h + 16'sd1, 16'sd9000); // parallel outside
            send_segment(h, -16'sd9000, h, 16'sd9000);                // parallel on edge
            send_segment(-16'sd9000, -h, 16'sd9000, -h);
            send_segment(-16'sd9000, -h - 16'sd1, 16'sd9000, -h - 16'sd1);
            send_segment(16'sd0, 16'sd2 * h, 16'sd2 * h, 16'sd0);     // touches corner once
            send_segment(16'sd8000, 16'sd8000, 16'sd9000, 16'sd12000); // outside the reset-size window, no cross
            send_segment(-16'sd20000, 16'sd3, 16'sd20000, -16'sd7);
            send_segment(16'sd3, -16'sd20000, -16'sd7, 16'sd20000);
            send_segment(16'sd0, 16'sd0, 16'sd20000, 16'sd20000);     // leaves through corner
            send_segment(16'sd5000, 16'sd4000, -16'sd4000, -16'sd5000);
        end
    endtask

    task automatic test_random(input int count);
        int i;
        begin
            for (i = 0; i < count; i++) begin
                if (i % 40 == 0) calm_mode = ($urandom_range(0, 3) == 0);
                send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
        end
    endtask

    task automatic test_window_sizes();
        begin
            set_window(15'd0);           // window is the origin alone
            send_segment(16'sd0, 16'sd0, 16'sd0, 16'sd0);
            send_segment(-16'sd5, -16'sd5, 16'sd5, 16'sd5);
            send_segment(-16'sd5, 16'sd0, 16'sd5, 16'sd1);
            test_random(40);
            set_window(15'h7fff);
            test_random(80);
            set_window(15'd1);
            test_random(40);
            set_window(15'd16384);
            test_random(80);
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_clip want;
        t_clip got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tuser, o_m_axis_tdata[0*COORD_BITS +: COORD_BITS],
                   o_m_axis_tdata[1*COORD_BITS +: COORD_BITS],
                   o_m_axis_tdata[2*COORD_BITS +: COORD_BITS],
                   o_m_axis_tdata[3*COORD_BITS +: COORD_BITS]};
            if (clip_queue.size() == 0) begin
                $error("Unexpected transaction: data %h user %b", o_m_axis_tdata, o_m_axis_tuser);
                error_count++;
            end else begin
                want = clip_queue.pop_front();
                if (got.visible !== want.visible) begin
                    $error("visible: expected %0d actual %0d", want.visible, got.visible);
                    error_count++;
                end
                if (got.sx !== want.sx) begin
                    $error("clip_start_x: expected %0d actual %0d", want.sx, got.sx);
                    error_count++;
                end
                if (got.sy !== want.sy) begin
                    $error("clip_start_y: expected %0d actual %0d", want.sy, got.sy);
                    error_count++;
                end
                if (got.ex !== want.ex) begin
                    $error("clip_end_x: expected %0d actual %0d", want.ex, got.ex);
                    error_count++;
                end
                if (got.ey !== want.ey) begin
                    $error("clip_end_y: expected %0d actual %0d", want.ey, got.ey);
                    error_count++;
                end
            end
        end
    end

    // Output back-pressure: calm stretches keep ready high, and now and then
    // ready stays low for a long stretch.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (calm_mode) begin
            i_m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 99) < 70) begin
            i_m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
            i_m_axis_tready <= 1'b0;
            ready_hold <= $urandom_range(10, 40);
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 1) == 1);
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        window_half = HALF_RESET;
        error_count = 0;
        idle_cycles = 0;
        ready_hold = 0;
        timed_out = 1'b0;
        calm_mode = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(140);
        set_window(15'd8192);
        test_directed();
        test_random(100);
        test_window_sizes();

        wait_drained();
        if (error_count == 0 && clip_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ square_window_line_clipper_top.f @@
hdl/swlc_pkg.sv
hdl/swlc_front.sv
hdl/swlc_fifo.sv
hdl/swlc_div.sv
hdl/swlc_back.sv
hdl/square_window_line_clipper_top.sv
verif/testbench.sv
